// File: rtl/ssd_pkg.sv
package ssd_pkg;

    // fixed field widths
    localparam int BITS_PER_BYTE = 8;
    localparam int DIGIT_COUNT   = 4;
    localparam int FRAME_BITS    = 2 * BITS_PER_BYTE;
    localparam int CNT_W         = $clog2(FRAME_BITS);
    localparam int FUNC_W        = 2;
    localparam int POS_W         = $clog2(DIGIT_COUNT);
    localparam int VALUE_W       = 14;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;

    localparam logic [VALUE_W-1:0]       NUMBER_LIMIT  = 14'd9999;
    localparam logic [BITS_PER_BYTE-1:0] BLANK_PATTERN = 8'hFF;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_NUMBER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DIGIT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHAR   = 2'd2;

    // one queued frame: segment byte, digit position, end of command
    typedef struct packed {
        logic [BITS_PER_BYTE-1:0] seg;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } frame_t;

    typedef enum logic {
        F_IDLE,
        F_DIGITS
    } front_state_t;

    // active-low segment pattern of a decimal digit, blank above nine
    function automatic logic [BITS_PER_BYTE-1:0] digit_pattern(input logic [DIGIT_W-1:0] d);
        logic [BITS_PER_BYTE-1:0] p;
        case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = BLANK_PATTERN;
        endcase
        return p;
    endfunction

    // letter pattern by the low five bits of the code, 1 is A
    function automatic logic [BITS_PER_BYTE-1:0] letter_pattern(input logic [4:0] l);
        logic [BITS_PER_BYTE-1:0] p;
        case (l)
            5'd1:    p = 8'h88;
            5'd2:    p = 8'h83;
            5'd3:    p = 8'hC6;
            5'd4:    p = 8'hA1;
            5'd5:    p = 8'h86;
            5'd6:    p = 8'h8E;
            5'd7:    p = 8'hC2;
            5'd8:    p = 8'h89;
            5'd9:    p = 8'hCF;
            5'd10:   p = 8'hE1;
            5'd11:   p = 8'h8A;
            5'd12:   p = 8'hC7;
            5'd13:   p = 8'hEA;
            5'd14:   p = 8'hC8;
            5'd15:   p = 8'hC0;
            5'd16:   p = 8'h8C;
            5'd17:   p = 8'h4A;
            5'd18:   p = 8'hCC;
            5'd19:   p = 8'h92;
            5'd20:   p = 8'h87;
            5'd21:   p = 8'hC1;
            5'd22:   p = 8'hC1;
            5'd23:   p = 8'hD5;
            5'd24:   p = 8'h89;
            5'd25:   p = 8'h91;
            5'd26:   p = 8'hA4;
            default: p = BLANK_PATTERN;
        endcase
        return p;
    endfunction

    // upper and lower case letters share the low five bits; all else blank
    function automatic logic [BITS_PER_BYTE-1:0] char_pattern(input logic [CHAR_W-1:0] c);
        logic [BITS_PER_BYTE-1:0] p;
        if (c[7:6] == 2'b01)
            p = letter_pattern(c[4:0]);
        else
            p = BLANK_PATTERN;
        return p;
    endfunction

    // digit-select byte, high nibble always set
    function automatic logic [BITS_PER_BYTE-1:0] select_pattern(input logic [POS_W-1:0] pos);
        logic [BITS_PER_BYTE-1:0] p;
        case (pos)
            2'd0:    p = 8'hF1;
            2'd1:    p = 8'hF2;
            2'd2:    p = 8'hF4;
            default: p = 8'hF8;
        endcase
        return p;
    endfunction

    // decimal weight of a digit position, thousands first
    function automatic logic [VALUE_W-1:0] digit_weight(input logic [POS_W-1:0] pos);
        logic [VALUE_W-1:0] w;
        case (pos)
            2'd0:    w = 14'd1000;
            2'd1:    w = 14'd100;
            2'd2:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/ssd_fifo.sv
module ssd_fifo
    import ssd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output frame_t pop_frame,
    output logic   empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_frame = mem[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // frame storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// File: rtl/ssd_front.sv
module ssd_front
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [POS_W-1:0]    position,
    input  logic [VALUE_W-1:0]  value,
    input  logic [CHAR_W-1:0]   character,
    output logic                push,
    output frame_t              push_frame,
    input  logic                full
);

    front_state_t           state_reg;
    front_state_t           state_next;
    logic [VALUE_W-1:0]     rem_reg;
    logic [VALUE_W-1:0]     rem_next;
    logic [POS_W-1:0]       dig_reg;
    logic [POS_W-1:0]       dig_next;
    logic                   accept;
    logic [VALUE_W-1:0]     weight;
    logic [DIGIT_W-1:0]     digit;
    logic [VALUE_W+DIGIT_W-1:0] taken;

    assign busy   = (state_reg != F_IDLE) || full;
    assign accept = start && !busy;

    // one decimal digit per cycle while the queue is not full: count how many multiples of the weight fit
    always_comb
    begin
        weight = digit_weight(dig_reg);
        digit  = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({{DIGIT_W{1'b0}}, rem_reg} >= (DIGIT_W + VALUE_W)'(k) * {{DIGIT_W{1'b0}}, weight})
            begin
                digit = DIGIT_W'(k);
            end
        end
        taken = (DIGIT_W + VALUE_W)'(digit) * {{DIGIT_W{1'b0}}, weight};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && func == FUNC_NUMBER && value <= NUMBER_LIMIT)
                begin
                    state_next = F_DIGITS;
                end
            end
            F_DIGITS:
            begin
                if (!full && dig_reg == POS_W'(DIGIT_COUNT - 1))
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // outputs and digit registers
    always_comb
    begin
        push       = 1'b0;
        push_frame = '0;
        rem_next   = rem_reg;
        dig_next   = dig_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_NUMBER:
                        begin
                            rem_next = value;
                            dig_next = '0;
                        end
                        FUNC_DIGIT:
                        begin
                            push            = 1'b1;
                            push_frame.seg  = (value <= VALUE_W'(9)) ?
                                              digit_pattern(value[DIGIT_W-1:0]) : BLANK_PATTERN;
                            push_frame.pos  = position;
                            push_frame.last = 1'b1;
                        end
                        FUNC_CHAR:
                        begin
                            push            = 1'b1;
                            push_frame.seg  = char_pattern(character);
                            push_frame.pos  = position;
                            push_frame.last = 1'b1;
                        end
                        default:
                        begin
                            push = 1'b0;
                        end
                    endcase
                end
            end
            F_DIGITS:
            begin
                if (!full)
                begin
                    push            = 1'b1;
                    push_frame.seg  = digit_pattern(digit);
                    push_frame.pos  = dig_reg;
                    push_frame.last = (dig_reg == POS_W'(DIGIT_COUNT - 1));
                    rem_next        = rem_reg - taken[VALUE_W-1:0];
                    dig_next        = dig_reg + 1'b1;
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            dig_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dig_reg   <= dig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

endmodule

// File: rtl/ssd_back.sv
module ssd_back
    import ssd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   empty,
    input  frame_t pop_frame,
    output logic   pop,
    output logic   strobe,
    output logic   data_bit,
    output logic   latch_after,
    output logic   last
);

    logic [FRAME_BITS-1:0] shift_reg;
    logic [FRAME_BITS-1:0] shift_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  active_reg;
    logic                  active_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  end_bit;

    assign end_bit     = active_reg && (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign pop         = (!active_reg || end_bit) && !empty;

    // serial word on the registered shifter, msb first
    assign strobe      = active_reg;
    assign data_bit    = shift_reg[FRAME_BITS-1];
    assign latch_after = end_bit;
    assign last        = end_bit && last_reg;

    // load a frame when idle or on the last bit of the current one
    always_comb
    begin
        shift_next  = shift_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        last_next   = last_reg;
        if (pop)
        begin
            shift_next  = {pop_frame.seg, select_pattern(pop_frame.pos)};
            cnt_next    = '0;
            active_next = 1'b1;
            last_next   = pop_frame.last;
        end
        else if (end_bit)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        last_reg  <= last_next;
    end

endmodule

// File: rtl/seven_segment_serial_driver.sv
// channel   signals                                   handshake
// command   func, position, value, character          start high, busy low
// bit word  data_bit, latch_after, last                strobe, one cycle, no stall
//
// each frame is 16 bits at one bit per cycle, set by the single serial
// shifter in the back end; a number is four frames, a digit or character one.
// the front end splits a number into the frame queue one digit per cycle unless
// it is full, so a new command is taken while earlier frames are still shifting out.
// busy is high while a number is being split or the frame queue is full.
// reset clears the queue, the decoder and the shifter; no clearing pass.
module seven_segment_serial_driver
    import ssd_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  func,
    input  logic [POS_W-1:0]   position,
    input  logic [VALUE_W-1:0] value,
    input  logic [CHAR_W-1:0]  character,
    output logic               strobe,
    output logic               data_bit,
    output logic               latch_after,
    output logic               last
);

    logic   push;
    frame_t push_frame;
    logic   full;
    logic   pop;
    frame_t pop_frame;
    logic   empty;

    // command decode and digit split
    ssd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .position   (position),
        .value      (value),
        .character  (character),
        .push       (push),
        .push_frame (push_frame),
        .full       (full)
    );

    // frame queue
    ssd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .empty      (empty)
    );

    // serializer
    ssd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .pop_frame   (pop_frame),
        .pop         (pop),
        .strobe      (strobe),
        .data_bit    (data_bit),
        .latch_after (latch_after),
        .last        (last)
    );

    // end of command only on a frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        last |-> (latch_after && strobe))
        else $error("last word without frame end");

    // latch mark only on a shown word
    assert property (@(posedge clk) disable iff (!rst_n)
        latch_after |-> strobe)
        else $error("latch mark without strobe");

    // a frame is never cut short
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !latch_after) |=> strobe)
        else $error("frame interrupted");

    // a valid number keeps the front busy while it is split
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_NUMBER && value <= NUMBER_LIMIT) |=> busy)
        else $error("number split not started");

endmodule

// File: tb/seven_segment_serial_driver_tb.sv
`timescale 1ns / 100ps

module seven_segment_serial_driver_tb;
    import ssd_pkg::*;

    // command code that the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // segment bytes, active low, first entry in the top byte
    localparam logic [79:0]  DIGIT_SEGS  = 80'hC0F9A4B0999282F88090;
    localparam logic [207:0] LETTER_SEGS =
        208'h8883C6A1868EC289CFE18AC7EAC8C08C4ACC9287C1C1D58991A4;
    localparam logic [31:0]  SELECT_BYTES = 32'hF1F2F4F8;
    localparam logic [7:0]   BLANK_SEG    = 8'hFF;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_ITEMS = 95;
    localparam int MAX_REPORTS  = 30;

    // one command, with an optional typed-in expectation
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        logic [CHAR_W-1:0]  chr;
        logic               typed;
        logic [2:0]         frames;
        logic [7:0]         seg;
    } cmd_row_t;

    // one serial bit word
    typedef struct packed {
        logic data_bit;
        logic latch_after;
        logic last;
    } bit_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FUNC_W-1:0]  func = FUNC_NUMBER;
    logic [POS_W-1:0]   position = '0;
    logic [VALUE_W-1:0] value = '0;
    logic [CHAR_W-1:0]  character = '0;
    logic               strobe;
    logic               data_bit;
    logic               latch_after;
    logic               last;

    // expectation that travels with the command being offered
    logic               row_typed = 1'b0;
    logic [2:0]         row_frames = '0;
    logic [7:0]         row_seg = '0;

    bit_word_t pending_bits [$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        burst_left = 0;

    cmd_row_t directed_rows [0:24] = '{
        '{FUNC_NUMBER, 2'd0, 14'd0,     8'h00, 1'b1, 3'd4, 8'hC0},
        '{FUNC_NUMBER, 2'd1, 14'd9999,  8'h00, 1'b1, 3'd4, 8'h90},
        '{FUNC_NUMBER, 2'd2, 14'd10000, 8'h00, 1'b1, 3'd0, 8'h00},
        '{FUNC_NUMBER, 2'd3, 14'd16383, 8'hFF, 1'b1, 3'd0, 8'h00},
        '{FUNC_NUMBER, 2'd3, 14'd1234,  8'h41, 1'b0, 3'd0, 8'h00},
        '{FUNC_NUMBER, 2'd2, 14'd8888,  8'h00, 1'b1, 3'd4, 8'h80},
        '{FUNC_DIGIT,  2'd0, 14'd0,     8'h00, 1'b1, 3'd1, 8'hC0},
        '{FUNC_DIGIT,  2'd3, 14'd9,     8'h00, 1'b1, 3'd1, 8'h90},
        '{FUNC_DIGIT,  2'd1, 14'd10,    8'h00, 1'b1, 3'd1, 8'hFF},
        '{FUNC_DIGIT,  2'd2, 14'd16383, 8'hFF, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd0, 14'd0,     8'h41, 1'b1, 3'd1, 8'h88},
        '{FUNC_CHAR,   2'd3, 14'd0,     8'h5A, 1'b1, 3'd1, 8'hA4},
        '{FUNC_CHAR,   2'd1, 14'd16383, 8'h61, 1'b1, 3'd1, 8'h88},
        '{FUNC_CHAR,   2'd2, 14'd0,     8'h7A, 1'b1, 3'd1, 8'hA4},
        '{FUNC_CHAR,   2'd0, 14'd0,     8'h20, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd1, 14'd0,     8'h40, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd2, 14'd0,     8'h5B, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd3, 14'd0,     8'h60, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd0, 14'd0,     8'h7B, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd1, 14'd0,     8'hFF, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd2, 14'd0,     8'h00, 1'b1, 3'd1, 8'hFF},
        '{FUNC_CHAR,   2'd3, 14'd0,     8'hC1, 1'b1, 3'd1, 8'hFF},
        '{FUNC_UNUSED, 2'd1, 14'd5,     8'h41, 1'b1, 3'd0, 8'h00},
        '{FUNC_CHAR,   2'd2, 14'd0,     8'h71, 1'b0, 3'd0, 8'h00},
        '{FUNC_NUMBER, 2'd0, 14'd5070,  8'h00, 1'b0, 3'd0, 8'h00}
    };

    seven_segment_serial_driver dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .position    (position),
        .value       (value),
        .character   (character),
        .strobe      (strobe),
        .data_bit    (data_bit),
        .latch_after (latch_after),
        .last        (last)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // segment byte of one decimal digit, blank above nine
    function automatic logic [7:0] seg_of_digit(input int unsigned d);
        if (d > 9)
            return BLANK_SEG;
        return DIGIT_SEGS[79 - 8 * d -: 8];
    endfunction

    // segment byte of one character, lowercase folded, non-letters blank
    function automatic logic [7:0] seg_of_char(input logic [CHAR_W-1:0] c);
        int unsigned code;
        code = c;
        if (code >= 8'h61 && code <= 8'h7A)
            code = code - 32;
        if (code >= 8'h41 && code <= 8'h5A)
            return LETTER_SEGS[207 - 8 * (code - 8'h41) -: 8];
        return BLANK_SEG;
    endfunction

    // queue the 16 bit words of one frame, msb first
    function automatic void push_frame(input logic [7:0] seg, input logic [POS_W-1:0] pos,
                                       input logic ends_command);
        logic [15:0] frame;
        bit_word_t   w;
        frame = {seg, SELECT_BYTES[31 - 8 * pos -: 8]};
        for (int i = 0; i < 16; i++)
        begin
            w.data_bit    = frame[15 - i];
            w.latch_after = (i == 15);
            w.last        = ends_command && (i == 15);
            pending_bits.push_back(w);
        end
    endfunction

    // expected bit stream of one command
    function automatic void predict_serial_bits(input logic [FUNC_W-1:0] f,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VALUE_W-1:0] v,
                                                input logic [CHAR_W-1:0] c);
        int unsigned n;
        n = v;
        case (f)
            FUNC_NUMBER:
            begin
                if (n <= 9999)
                begin
                    push_frame(seg_of_digit(n / 1000), 2'd0, 1'b0);
                    push_frame(seg_of_digit((n / 100) % 10), 2'd1, 1'b0);
                    push_frame(seg_of_digit((n / 10) % 10), 2'd2, 1'b0);
                    push_frame(seg_of_digit(n % 10), 2'd3, 1'b1);
                end
            end
            FUNC_DIGIT: push_frame(seg_of_digit(n), pos, 1'b1);
            FUNC_CHAR:  push_frame(seg_of_char(c), pos, 1'b1);
            default:    ;
        endcase
    endfunction

    // bit stream from a typed-in segment byte and frame count
    function automatic void push_typed_frames(input logic [2:0] frames, input logic [7:0] seg,
                                              input logic [POS_W-1:0] pos);
        if (frames == 3'd1)
            push_frame(seg, pos, 1'b1);
        else if (frames == 3'd4)
            for (int k = 0; k < 4; k++)
                push_frame(seg, POS_W'(k), k == 3);
    endfunction

    task automatic report_mismatch(input string what, input logic expected, input logic seen);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0b got %0b", $realtime, what, expected, seen);
        mismatch_count++;
    endtask

    // take commands and check every bit word against the oldest expectation
    always @(posedge clk)
    begin : check_bits
        bit_word_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                if (row_typed)
                    push_typed_frames(row_frames, row_seg, position);
                else
                    predict_serial_bits(func, position, value, character);
            end
            if (strobe)
            begin
                if (pending_bits.size() == 0)
                begin
                    report_mismatch("strobe with no word expected", 1'b0, strobe);
                end
                else
                begin
                    want = pending_bits.pop_front();
                    if (data_bit !== want.data_bit)
                        report_mismatch("data_bit", want.data_bit, data_bit);
                    if (latch_after !== want.latch_after)
                        report_mismatch("latch_after", want.latch_after, latch_after);
                    if (last !== want.last)
                        report_mismatch("last", want.last, last);
                end
            end
        end
    end

    // watchdog on cycles with no command and no bit word
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("seven_segment_serial_driver test failed");
            $finish;
        end
    end

    // bursts of back-to-back commands with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 6);
        end
        burst_left--;
    endtask

    // offer one command and hold it until taken
    task automatic issue_command(input cmd_row_t r);
        start      <= 1'b1;
        func       <= r.func;
        position   <= r.pos;
        value      <= r.value;
        character  <= r.chr;
        row_typed  <= r.typed;
        row_frames <= r.frames;
        row_seg    <= r.seg;
        do
            @(posedge clk);
        while (busy);
    endtask

    // random command, mostly well-formed, with noise in unused fields
    function automatic cmd_row_t random_command();
        cmd_row_t r;
        int       pick;
        r.func   = FUNC_W'($urandom_range(0, 3));
        r.pos    = POS_W'($urandom_range(0, 3));
        r.value  = VALUE_W'($urandom_range(0, 16383));
        r.chr    = CHAR_W'($urandom_range(0, 255));
        r.typed  = 1'b0;
        r.frames = '0;
        r.seg    = '0;
        pick = $urandom_range(0, 19);
        if (pick <= 6)
        begin
            r.func  = FUNC_NUMBER;
            r.value = (pick == 0) ? VALUE_W'($urandom_range(10000, 16383))
                                  : VALUE_W'($urandom_range(0, 9999));
        end
        else if (pick <= 10)
        begin
            r.func  = FUNC_DIGIT;
            r.value = (pick == 7) ? VALUE_W'($urandom_range(10, 16383))
                                  : VALUE_W'($urandom_range(0, 9));
        end
        else if (pick <= 17)
        begin
            r.func = FUNC_CHAR;
            if (pick <= 13)
                r.chr = CHAR_W'(8'h41 + $urandom_range(0, 25));
            else if (pick <= 15)
                r.chr = CHAR_W'(8'h61 + $urandom_range(0, 25));
            else if (pick == 16)
                r.chr = 8'h20;
        end
        else if (pick == 18)
            r.func = FUNC_UNUSED;
        else
            r.func = FUNC_DIGIT;
        return r;
    endfunction

    // reset, directed table, random commands, drain
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            pace_sender();
            issue_command(directed_rows[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pace_sender();
            issue_command(random_command());
        end
        start <= 1'b0;

        while (pending_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("seven_segment_serial_driver test passed");
        else
            $display("seven_segment_serial_driver test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ssd_pkg.sv
rtl/ssd_fifo.sv
rtl/ssd_front.sv
rtl/ssd_back.sv
rtl/seven_segment_serial_driver.sv
tb/seven_segment_serial_driver_tb.sv
